// ===== src/i2cm_pkg.sv =====
// Package for the I2C bit-level master line sequencer.
// Holds request codes, register indexes, sequence phases and the beat structs.
// No dependencies; every other file in src uses it by scoped names.
package i2cm_pkg;

   // Request codes carried by an input beat.
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_STOP     = 3'd2;
   localparam logic [2:0] CMD_WRITE    = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;
   localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

   // Configuration register indexes and their reset values.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_UNIT = 2'd1;
   localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;
   localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd1;

   // Segment lengths in delay units.
   localparam logic [2:0] UNITS_EDGE = 3'd4;
   localparam logic [2:0] UNITS_BIT  = 3'd2;
   localparam logic [2:0] UNITS_ONE  = 3'd1;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Sequence phases, one-hot.
   typedef enum logic [16:0] {
      PH_IDLE = 17'h00001,
      PH_ST_A = 17'h00002,
      PH_ST_B = 17'h00004,
      PH_SP_A = 17'h00008,
      PH_SP_B = 17'h00010,
      PH_FS_A = 17'h00020,
      PH_FS_B = 17'h00040,
      PH_WR_A = 17'h00080,
      PH_WR_B = 17'h00100,
      PH_WR_C = 17'h00200,
      PH_RD_A = 17'h00400,
      PH_RD_B = 17'h00800,
      PH_AK_A = 17'h01000,
      PH_AK_B = 17'h02000,
      PH_WA_A = 17'h04000,
      PH_WA_B = 17'h08000,
      PH_WA_P = 17'h10000
   } phase_type;

   // Levels the master puts on the bus.
   typedef struct packed {
      logic scl;
      logic sda;
      logic en;
   } line_type;

   // One input beat.
   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_level;
   } req_item_type;

   // One result beat.
   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_enable;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       ack_failed;
      logic       cmd_dropped;
   } rsp_item_type;

   // Configuration seen by the sequencer.
   typedef struct packed {
      logic [7:0] ack_timeout;
      logic [7:0] ticks_per_unit;
   } cfg_type;

   // Status of the sequencer before the current beat is applied.
   typedef struct packed {
      logic busy;
   } seq_status_type;

endpackage

// ===== src/i2cm_csr.sv =====
// Configuration registers of the I2C line sequencer.
// Depends on i2cm_pkg for register indexes, reset values and cfg_type.
module i2cm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_data,
   output i2cm_pkg::cfg_type                cfg
);

   logic [7:0] ack_timeout_ff;
   logic [7:0] ack_timeout_in;
   logic [7:0] ticks_per_unit_ff;
   logic [7:0] ticks_per_unit_in;

   // Writes are always taken; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      ack_timeout_in    = ack_timeout_ff;
      ticks_per_unit_in = ticks_per_unit_ff;
      if (csr_valid) begin
         case (csr_index)
            i2cm_pkg::CSR_ACK_TIMEOUT:    ack_timeout_in    = csr_data;
            i2cm_pkg::CSR_TICKS_PER_UNIT: ticks_per_unit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff    <= i2cm_pkg::ACK_TIMEOUT_RST;
         ticks_per_unit_ff <= i2cm_pkg::TICKS_PER_UNIT_RST;
      end else begin
         ack_timeout_ff    <= ack_timeout_in;
         ticks_per_unit_ff <= ticks_per_unit_in;
      end
   end

   assign cfg.ack_timeout    = ack_timeout_ff;
   assign cfg.ticks_per_unit = ticks_per_unit_ff;

endmodule

// ===== src/i2cm_seq.sv =====
// Sequencer state and one-tick update logic of the I2C line sequencer.
// Depends on i2cm_pkg for phases, line levels and the beat structs.
module i2cm_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  i2cm_pkg::req_item_type        item,
   input  i2cm_pkg::cfg_type             cfg,
   output i2cm_pkg::rsp_item_type        rsp,
   output i2cm_pkg::seq_status_type      status
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   i2cm_pkg::line_type  line_ff, line_in;
   logic [3:0] bit_ff, bit_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] pre_ff, pre_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] wait_ff, wait_in;
   logic       ackc_ff, ackc_in;
   logic [7:0] rx_ff, rx_in;
   logic       fail_ff, fail_in;
   logic       done;
   logic       dropped;

   logic [7:0] per;
   logic [7:0] pre_inc;
   logic [2:0] cnt_dec;
   logic [3:0] bit_inc;
   logic [7:0] shift_up;

   // Prescaler period, unit countdown and bit counter steps.
   assign per      = (cfg.ticks_per_unit == 8'd0) ? 8'd1 : cfg.ticks_per_unit;
   assign pre_inc  = pre_ff + 8'd1;
   assign cnt_dec  = (cnt_ff != 3'd0) ? cnt_ff - 3'd1 : 3'd0;
   assign bit_inc  = bit_ff + 4'd1;
   assign shift_up = {shift_ff[6:0], 1'b0};

   // Next state for one tick.
   always_comb begin
      phase_in = phase_ff;
      line_in  = line_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      pre_in   = pre_ff;
      shift_in = shift_ff;
      wait_in  = wait_ff;
      ackc_in  = ackc_ff;
      rx_in    = rx_ff;
      fail_in  = fail_ff;
      done     = 1'b0;
      dropped  = 1'b0;

      if (phase_ff == i2cm_pkg::PH_IDLE) begin
         // Idle: take a new command.
         bit_in = 4'd0;
         case (item.req_type)
            i2cm_pkg::CMD_START: begin
               phase_in = i2cm_pkg::PH_ST_A;
               line_in  = '{scl: 1'b1, sda: 1'b1, en: 1'b1};
               cnt_in   = i2cm_pkg::UNITS_EDGE;
               pre_in   = 8'd0;
            end
            i2cm_pkg::CMD_STOP: begin
               phase_in = i2cm_pkg::PH_SP_A;
               line_in  = '{scl: 1'b0, sda: 1'b0, en: 1'b1};
               cnt_in   = i2cm_pkg::UNITS_EDGE;
               pre_in   = 8'd0;
            end
            i2cm_pkg::CMD_WRITE: begin
               shift_in = item.tx_byte;
               phase_in = i2cm_pkg::PH_WR_A;
               line_in  = '{scl: 1'b0, sda: item.tx_byte[7], en: 1'b1};
               cnt_in   = i2cm_pkg::UNITS_BIT;
               pre_in   = 8'd0;
            end
            i2cm_pkg::CMD_READ: begin
               shift_in = 8'd0;
               ackc_in  = item.send_ack;
               phase_in = i2cm_pkg::PH_RD_A;
               line_in  = '{scl: 1'b0, sda: line_ff.sda, en: 1'b0};
               cnt_in   = i2cm_pkg::UNITS_BIT;
               pre_in   = 8'd0;
            end
            i2cm_pkg::CMD_WAIT_ACK: begin
               wait_in  = 8'd0;
               fail_in  = 1'b0;
               phase_in = i2cm_pkg::PH_WA_A;
               line_in  = '{scl: line_ff.scl, sda: 1'b1, en: 1'b0};
               cnt_in   = i2cm_pkg::UNITS_ONE;
               pre_in   = 8'd0;
            end
            default: ;
         endcase
      end else begin
         // Busy: commands are dropped, the prescaler runs.
         dropped = (item.req_type >= i2cm_pkg::CMD_START) &&
                   (item.req_type <= i2cm_pkg::CMD_WAIT_ACK);
         if (pre_inc >= per) begin
            pre_in = 8'd0;
            cnt_in = cnt_dec;
            if (cnt_dec == 3'd0) begin
               // End of a segment: move to the next one.
               case (phase_ff)
                  i2cm_pkg::PH_ST_A: begin
                     phase_in = i2cm_pkg::PH_ST_B;
                     line_in  = '{scl: 1'b1, sda: 1'b0, en: 1'b1};
                     cnt_in   = i2cm_pkg::UNITS_EDGE;
                  end
                  i2cm_pkg::PH_ST_B: begin
                     line_in.scl = 1'b0;
                     phase_in    = i2cm_pkg::PH_IDLE;
                     done        = 1'b1;
                  end
                  i2cm_pkg::PH_SP_A: begin
                     phase_in = i2cm_pkg::PH_SP_B;
                     line_in  = '{scl: 1'b1, sda: 1'b1, en: 1'b1};
                     cnt_in   = i2cm_pkg::UNITS_EDGE;
                  end
                  i2cm_pkg::PH_SP_B: begin
                     phase_in = i2cm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
                  i2cm_pkg::PH_FS_A: begin
                     phase_in = i2cm_pkg::PH_FS_B;
                     line_in  = '{scl: 1'b1, sda: 1'b1, en: 1'b1};
                     cnt_in   = i2cm_pkg::UNITS_EDGE;
                  end
                  i2cm_pkg::PH_FS_B: begin
                     fail_in  = 1'b1;
                     phase_in = i2cm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
                  i2cm_pkg::PH_WR_A: begin
                     phase_in = i2cm_pkg::PH_WR_B;
                     line_in  = '{scl: 1'b1, sda: line_ff.sda, en: 1'b1};
                     cnt_in   = i2cm_pkg::UNITS_BIT;
                  end
                  i2cm_pkg::PH_WR_B: begin
                     phase_in = i2cm_pkg::PH_WR_C;
                     line_in  = '{scl: 1'b0, sda: line_ff.sda, en: 1'b1};
                     cnt_in   = i2cm_pkg::UNITS_BIT;
                  end
                  i2cm_pkg::PH_WR_C: begin
                     bit_in = bit_inc;
                     if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        phase_in = i2cm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        shift_in = shift_up;
                        phase_in = i2cm_pkg::PH_WR_A;
                        line_in  = '{scl: 1'b0, sda: shift_up[7], en: 1'b1};
                        cnt_in   = i2cm_pkg::UNITS_BIT;
                     end
                  end
                  i2cm_pkg::PH_RD_A: begin
                     // Sample SDA as SCL rises.
                     shift_in = {shift_ff[6:0], item.sda_level};
                     phase_in = i2cm_pkg::PH_RD_B;
                     line_in  = '{scl: 1'b1, sda: line_ff.sda, en: 1'b0};
                     cnt_in   = i2cm_pkg::UNITS_ONE;
                  end
                  i2cm_pkg::PH_RD_B: begin
                     bit_in = bit_inc;
                     if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        phase_in = i2cm_pkg::PH_AK_A;
                        line_in  = '{scl: 1'b0, sda: !ackc_ff, en: 1'b1};
                     end else begin
                        phase_in = i2cm_pkg::PH_RD_A;
                        line_in  = '{scl: 1'b0, sda: line_ff.sda, en: 1'b0};
                     end
                     cnt_in = i2cm_pkg::UNITS_BIT;
                  end
                  i2cm_pkg::PH_AK_A: begin
                     phase_in = i2cm_pkg::PH_AK_B;
                     line_in  = '{scl: 1'b1, sda: line_ff.sda, en: 1'b1};
                     cnt_in   = i2cm_pkg::UNITS_BIT;
                  end
                  i2cm_pkg::PH_AK_B: begin
                     line_in.scl = 1'b0;
                     rx_in       = shift_ff;
                     phase_in    = i2cm_pkg::PH_IDLE;
                     done        = 1'b1;
                  end
                  i2cm_pkg::PH_WA_A: begin
                     phase_in = i2cm_pkg::PH_WA_B;
                     line_in  = '{scl: 1'b1, sda: 1'b1, en: 1'b0};
                     cnt_in   = i2cm_pkg::UNITS_ONE;
                  end
                  i2cm_pkg::PH_WA_B: begin
                     phase_in = i2cm_pkg::PH_WA_P;
                     line_in  = '{scl: 1'b1, sda: 1'b1, en: 1'b0};
                     cnt_in   = i2cm_pkg::UNITS_ONE;
                  end
                  i2cm_pkg::PH_WA_P: begin
                     // Poll: low SDA is an acknowledge, too many highs fail.
                     if (!item.sda_level) begin
                        line_in.scl = 1'b0;
                        phase_in    = i2cm_pkg::PH_IDLE;
                        done        = 1'b1;
                     end else if (wait_ff >= cfg.ack_timeout) begin
                        phase_in = i2cm_pkg::PH_FS_A;
                        line_in  = '{scl: 1'b0, sda: 1'b0, en: 1'b1};
                        cnt_in   = i2cm_pkg::UNITS_EDGE;
                     end else begin
                        wait_in = wait_ff + 8'd1;
                        cnt_in  = i2cm_pkg::UNITS_ONE;
                     end
                  end
                  default: begin
                     phase_in = i2cm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
               endcase
            end
         end else begin
            pre_in = pre_inc;
         end
      end
   end

   // State registers, updated once per beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_IDLE;
         line_ff  <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
         bit_ff   <= 4'd0;
         cnt_ff   <= 3'd0;
         pre_ff   <= 8'd0;
         shift_ff <= 8'd0;
         wait_ff  <= 8'd0;
         ackc_ff  <= 1'b0;
         rx_ff    <= 8'd0;
         fail_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         bit_ff   <= bit_in;
         cnt_ff   <= cnt_in;
         pre_ff   <= pre_in;
         shift_ff <= shift_in;
         wait_ff  <= wait_in;
         ackc_ff  <= ackc_in;
         rx_ff    <= rx_in;
         fail_ff  <= fail_in;
      end
   end

   // Result beat shows the state after this tick.
   assign rsp.scl_level   = line_in.scl;
   assign rsp.sda_drive   = line_in.sda;
   assign rsp.sda_enable  = line_in.en;
   assign rsp.busy_res    = (phase_in != i2cm_pkg::PH_IDLE);
   assign rsp.done_res    = done;
   assign rsp.rx_data     = rx_in;
   assign rsp.ack_failed  = fail_in;
   assign rsp.cmd_dropped = dropped;

   assign status.busy = (phase_ff != i2cm_pkg::PH_IDLE);

endmodule

// ===== src/i2c_bit_level_master.sv =====
// An accepted beat is held in the input register, its result in the result
// register, which decouple the channels. Throughput: one beat per cycle while
// rsp_stall is low; the sequencer update is one short step per tick.
// Reset is synchronous and active high: the bus idles with SCL and SDA driven
// high, registers return to ack_timeout 250 and ticks_per_unit 1.
// Depends on i2cm_pkg, i2cm_csr and i2cm_seq.
module i2c_bit_level_master (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_type,
   input  logic [7:0]                       req_tx_byte,
   input  logic                             req_send_ack,
   input  logic                             req_sda_level,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_scl_level,
   output logic                             rsp_sda_drive,
   output logic                             rsp_sda_enable,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [7:0]                       rsp_rx_data,
   output logic                             rsp_ack_failed,
   output logic                             rsp_cmd_dropped,
   // Configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_data
);

   logic                       in_valid_ff, in_valid_in;
   i2cm_pkg::req_item_type     item_ff, item_in;
   logic                       out_valid_ff, out_valid_in;
   i2cm_pkg::rsp_item_type     out_ff, out_in;
   logic                       advance;
   i2cm_pkg::cfg_type          cfg;
   i2cm_pkg::rsp_item_type     seq_rsp;
   i2cm_pkg::seq_status_type   seq_status;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .rsp     (seq_rsp),
      .status  (seq_status)
   );

   // The held beat moves on when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         item_in     = '{req_type: req_type, tx_byte: req_tx_byte,
                         send_ack: req_send_ack, sda_level: req_sda_level};
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = seq_rsp;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scl_level   = out_ff.scl_level;
   assign rsp_sda_drive   = out_ff.sda_drive;
   assign rsp_sda_enable  = out_ff.sda_enable;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_done_res    = out_ff.done_res;
   assign rsp_rx_data     = out_ff.rx_data;
   assign rsp_ack_failed  = out_ff.ack_failed;
   assign rsp_cmd_dropped = out_ff.cmd_dropped;

   // A finishing tick never reports the sequence as still busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done and busy reported in the same beat");

   // A command is only reported dropped while a sequence was running.
   a_drop_only_busy: assert property (@(posedge clock) disable iff (reset)
      advance && !seq_status.busy |-> !seq_rsp.cmd_dropped)
      else $error("command dropped while idle");

   // A beat that moves on lands in the result register.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced beat lost before the result register");

endmodule
